@@ design/ordered_list_tail_insert_delete_assert.svh @@
// Assertion macros used by the checker of the ordered list block.
`ifndef ORDERED_LIST_TAIL_INSERT_DELETE_ASSERT_SVH
`define ORDERED_LIST_TAIL_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define OLTID_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list check failed: same-cycle rule");

// Next-cycle implication, sampled on clk and disabled during reset.
`define OLTID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list check failed: next-cycle rule");

`endif

@@ design/oltid_pkg.sv @@
// Package with field widths, request kinds, status codes and the result type.
package oltid_pkg;

    localparam int KIND_W     = 2;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 7;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 7;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam kind_t KIND_APPEND  = 2'd0;
    localparam kind_t KIND_HEAD    = 2'd1;
    localparam kind_t KIND_TAIL    = 2'd2;
    localparam kind_t KIND_POS     = 2'd3;

    localparam status_t ST_INSERTED = 3'd0;
    localparam status_t ST_REMOVED  = 3'd1;
    localparam status_t ST_EMPTY    = 3'd2;
    localparam status_t ST_BADPOS   = 3'd3;
    localparam status_t ST_FULL     = 3'd4;

    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   removed;
        logic [COUNT_W-1:0]   count;
    } result_t;

endpackage

@@ design/oltid_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module oltid_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/ordered_list_tail_insert_delete.sv @@
// Top level of the bounded ordered list: sequencer, count and output register.
// An append or a rejected request goes from idle to the done state, which hands its
// result to the output register once that is free. A removal reads the chosen entry
// in the take state, then closes up any later entries one entry per cycle in the shift state.
// One transaction is in work at a time; the next is accepted once the result is offered.
// Reset (rst_n low, asynchronous) empties the list; entry contents are left as they are.
module ordered_list_tail_insert_delete #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata fields from bit 0 up: value[31:0], position[38:32], zero pad[39].
    input  logic [oltid_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser fields from bit 0 up: kind[1:0].
    input  logic [oltid_pkg::KIND_W-1:0]        s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata fields from bit 0 up: removed_value[31:0], entry_count[38:32], zero pad[39].
    output logic [oltid_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser fields from bit 0 up: status[2:0].
    output logic [oltid_pkg::STATUS_W-1:0]      m_axis_tuser
);

    import oltid_pkg::*;

    // Address width of the entry store and width of the entry counter, which
    // must be able to hold CAPACITY itself.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // Common width for comparing the requested position against the count.
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_TAKE  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    result_t       pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    // Entry store ports.
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic               in_accept;
    kind_t              in_kind;
    logic [VALUE_W-1:0] in_value;
    logic [POS_W-1:0]   in_pos;
    logic [MW-1:0]      pos_ext;
    logic [MW-1:0]      cnt_ext;
    logic [CW-1:0]      idx_ext;
    logic               list_full;
    logic               take_ok;
    logic [AW-1:0]      take_idx;
    logic               out_free;

    oltid_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (VALUE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Requests are taken only while the sequencer is idle.
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign in_kind  = s_axis_tuser;
    assign in_value = s_axis_tdata[VALUE_W-1:0];
    assign in_pos   = s_axis_tdata[VALUE_W+POS_W-1:VALUE_W];

    assign pos_ext   = MW'(in_pos);
    assign cnt_ext   = MW'(cnt_reg);
    assign idx_ext   = CW'(idx_reg);
    assign list_full = (cnt_reg >= CW'(CAPACITY));

    // The output register is free when empty or when its transaction completes now.
    assign out_free = !out_valid_reg || m_axis_tready;

    // Decode which entry a removal takes out. A position of zero or beyond the
    // count is refused; the empty case is handled ahead of this.
    always_comb
    begin
        take_ok  = 1'b1;
        take_idx = '0;
        case (in_kind)
            KIND_HEAD:
            begin
                take_idx = '0;
            end
            KIND_TAIL:
            begin
                take_idx = AW'(cnt_reg - CW'(1));
            end
            KIND_POS:
            begin
                if ((pos_ext == '0) || (pos_ext > cnt_ext))
                begin
                    take_ok = 1'b0;
                end
                take_idx = AW'(pos_ext - MW'(1));
            end
            default:
            begin
                take_ok = 1'b0;
            end
        endcase
    end

    // Sequencer. An append writes the tail in the accept cycle. A removal reads
    // the chosen entry, then moves each later entry down by one: every shift
    // cycle writes the word read in the cycle before and reads the next one, if any.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    pend_next.removed = '0;
                    state_next        = S_DONE;
                    if (in_kind == KIND_APPEND)
                    begin
                        if (list_full)
                        begin
                            pend_next.status = ST_FULL;
                        end
                        else
                        begin
                            ram_we           = 1'b1;
                            ram_waddr        = AW'(cnt_reg);
                            ram_wdata        = in_value;
                            cnt_next         = cnt_reg + CW'(1);
                            pend_next.status = ST_INSERTED;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        pend_next.status = ST_EMPTY;
                    end
                    else if (!take_ok)
                    begin
                        pend_next.status = ST_BADPOS;
                    end
                    else
                    begin
                        ram_re           = 1'b1;
                        ram_raddr        = take_idx;
                        idx_next         = take_idx;
                        pend_next.status = ST_REMOVED;
                        state_next       = S_TAKE;
                    end
                end
            end
            S_TAKE:
            begin
                // The removed word has arrived; start closing up if entries follow.
                pend_next.removed = ram_rdata;
                if ((idx_ext + CW'(1)) < cnt_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(idx_ext + CW'(1));
                    state_next = S_SHIFT;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if ((idx_ext + CW'(2)) < cnt_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(idx_ext + CW'(2));
                    idx_next  = AW'(idx_ext + CW'(1));
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hand the result to the output register once it can take it.
                if (out_free)
                begin
                    out_next.status  = pend_reg.status;
                    out_next.removed = pend_reg.removed;
                    out_next.count   = COUNT_W'(cnt_reg);
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and index registers carry no reset.
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {{(OUT_DATA_W - COUNT_W - VALUE_W){1'b0}},
                            out_reg.count, out_reg.removed};

endmodule

@@ design/oltid_checker.sv @@
// Port-level checker for the ordered list block and its bind statement.
`include "ordered_list_tail_insert_delete_assert.svh"

module oltid_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [oltid_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [oltid_pkg::KIND_W-1:0]     s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [oltid_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [oltid_pkg::STATUS_W-1:0]   m_axis_tuser
);

    import oltid_pkg::*;

    // A result waiting for the sink stays offered.
    `OLTID_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // Every accepted request leaves the block busy in the next cycle.
    `OLTID_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Only a removal reports a nonzero removed value.
    `OLTID_ASSERT_NOW(a_removed_zero, m_axis_tvalid && (m_axis_tuser != ST_REMOVED), m_axis_tdata[VALUE_W-1:0] == '0)

    // An empty report always comes with a count of zero.
    `OLTID_ASSERT_NOW(a_empty_count, m_axis_tvalid && (m_axis_tuser == ST_EMPTY), m_axis_tdata[VALUE_W+COUNT_W-1:VALUE_W] == '0)

endmodule

bind ordered_list_tail_insert_delete oltid_checker u_oltid_checker (.*);
